>>> hdl/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// Shared types and codes for the LRU block cache directory.
// ----------------------------------------------------------------------------
package lbcd_pkg;

	localparam int USER_W = 31;
	localparam int BLOCK_W = 31;
	localparam int SLOT_W = 6;
	localparam int CFG_W = 7;
	localparam int STAT_W = 32;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_CLR_CACHE = 2'd2;
	localparam logic [1:0] OP_CLR_STATS = 2'd3;

	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_INDEX = 2'd2;

	localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = 7'd64;
	localparam logic [STAT_W-1:0] STAT_MAX = '1;

	typedef struct packed {
		logic [1:0] operation;
		logic [USER_W-1:0] user_id;
		logic [BLOCK_W-1:0] block_id;
		logic [1:0] access_kind;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] request_count;
		logic [STAT_W-1:0] data_page_count;
		logic [STAT_W-1:0] index_page_count;
		logic [STAT_W-1:0] sequential_count;
		logic [STAT_W-1:0] random_count;
	} stats_t;

	typedef struct packed {
		logic hit;
		logic [SLOT_W-1:0] slot;
		logic evicted;
		logic [STAT_W-1:0] request_count;
		logic [STAT_W-1:0] data_page_count;
		logic [STAT_W-1:0] index_page_count;
		logic [STAT_W-1:0] sequential_count;
		logic [STAT_W-1:0] random_count;
	} rsp_t;

	typedef struct packed {
		logic hit;
		logic empty;
	} scan_flags_t;

endpackage

>>> hdl/lru_block_cache_directory_top.sv
// ----------------------------------------------------------------------------
// lru_block_cache_directory_top
// Tag directory of a fully associative page cache with LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_stall carries one request word (lookup, store, clear
//   cache, clear statistics). rsp/rsp_valid/rsp_stall returns one result
//   word per request: hit, slot, evicted and the five statistics after the
//   request. cfg_valid/cfg_ready/cfg_data writes cache_entries; write it
//   only while no request is outstanding.
//   Lookup and store read every slot in use from the tag memory, one slot a
//   cycle. Clear cache sweeps all ENTRIES slots. One request is in work at a
//   time; the next is taken once the previous result sits in rsp.
//   After reset the tag memory is swept with req_stall high; configuration
//   writes are taken throughout.
//   A stalled result holds in rsp; a finished request waits for the result
//   register to free before writing back and updating statistics.
// ----------------------------------------------------------------------------
module lru_block_cache_directory_top #(
	parameter int ENTRIES = 64,
	parameter int STAMP_BITS = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lbcd_pkg::req_t           req,
	input  logic                     req_valid,
	output logic                     req_stall,
	output lbcd_pkg::rsp_t           rsp,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [lbcd_pkg::CFG_W-1:0] cfg_data
);
	import lbcd_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = 1 + USER_W + BLOCK_W + STAMP_BITS;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]            state_q;
	logic [CFG_W-1:0]      cache_entries_q;
	req_t                  req_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      n_sel;
	logic [31:0]           cfg_ext;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic [IDX_W-1:0]      clr_cnt_q;
	logic                  clr_last;
	logic                  rd_issue;
	logic                  rd_last;
	logic                  rd_s1;
	logic                  last_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic                  fire;
	logic                  accept;
	logic                  sweep;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [ENT_W-1:0]      mem_wdata;
	logic [ENT_W-1:0]      mem_rdata;

	scan_flags_t           flags;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      empty_idx;
	logic [IDX_W-1:0]      lru_idx;
	logic [IDX_W-1:0]      store_idx;
	logic [31:0]           slot_ext;
	stats_t                cnt_next;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign fire = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign sweep = (state_q == S_INIT) || (state_q == S_CLEAR);
	assign clr_last = (clr_cnt_q == IDX_W'(ENTRIES - 1));

	assign cfg_ext = 32'(cache_entries_q);
	assign n_sel = (cfg_ext == 32'd0) ? CNT_W'(1)
		: (cfg_ext > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cfg_ext);

	assign rd_issue = (state_q == S_SCAN) && (rd_cnt_q < n_q);
	assign rd_last = (rd_cnt_q + 1'b1 == n_q);

	assign store_idx = flags.empty ? empty_idx : lru_idx;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (sweep) begin
			mem_we = 1'b1;
		end else if (fire) begin
			mem_wdata = {1'b1, req_q.user_id, req_q.block_id, stamp_q};
			if (req_q.operation == OP_STORE) begin
				mem_we = 1'b1;
				mem_waddr = store_idx;
			end else if (req_q.operation == OP_LOOKUP && flags.hit) begin
				mem_we = 1'b1;
				mem_waddr = hit_idx;
			end
		end
	end

	lbcd_tag_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(ENT_W)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(rd_issue),
		.raddr(rd_cnt_q[IDX_W-1:0]),
		.rdata(mem_rdata)
	);

	lbcd_scan #(
		.ENTRIES(ENTRIES),
		.STAMP_BITS(STAMP_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.dv(rd_s1),
		.idx(idx_s1),
		.ent_valid(mem_rdata[ENT_W-1]),
		.ent_user(mem_rdata[ENT_W-2 -: USER_W]),
		.ent_block(mem_rdata[STAMP_BITS+BLOCK_W-1 -: BLOCK_W]),
		.ent_stamp(mem_rdata[STAMP_BITS-1:0]),
		.key_user(req_q.user_id),
		.key_block(req_q.block_id),
		.flags(flags),
		.hit_idx(hit_idx),
		.empty_idx(empty_idx),
		.lru_idx(lru_idx)
	);

	lbcd_stats u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.upd(fire),
		.op(req_q.operation),
		.kind(req_q.access_kind),
		.user(req_q.user_id),
		.block(req_q.block_id),
		.cnt_next(cnt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_entries_q <= CFG_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			cache_entries_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_cnt_q <= '0;
			rd_cnt_q <= '0;
			rd_s1 <= 1'b0;
			last_s1 <= 1'b0;
			stamp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_issue;
			last_s1 <= rd_issue && rd_last;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_cnt_q <= '0;
					clr_cnt_q <= '0;
					if (req_valid) begin
						case (req.operation)
							OP_LOOKUP, OP_STORE: state_q <= S_SCAN;
							OP_CLR_CACHE: state_q <= S_CLEAR;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (rd_s1 && last_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fire) begin
						state_q <= S_IDLE;
						case (req_q.operation)
							OP_LOOKUP: begin
								if (flags.hit) begin
									stamp_q <= stamp_q + 1'b1;
								end
							end
							OP_STORE: stamp_q <= stamp_q + 1'b1;
							OP_CLR_CACHE: stamp_q <= '0;
							default: stamp_q <= stamp_q;
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			n_q <= n_sel;
		end
		if (rd_issue) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
	end

	always_comb begin
		slot_ext = '0;
		if (req_q.operation == OP_STORE) begin
			slot_ext = 32'(store_idx);
		end else if (req_q.operation == OP_LOOKUP && flags.hit) begin
			slot_ext = 32'(hit_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.hit <= (req_q.operation == OP_LOOKUP) && flags.hit;
			rsp_q.slot <= slot_ext[SLOT_W-1:0];
			rsp_q.evicted <= (req_q.operation == OP_STORE) && !flags.empty;
			rsp_q.request_count <= cnt_next.request_count;
			rsp_q.data_page_count <= cnt_next.data_page_count;
			rsp_q.index_page_count <= cnt_next.index_page_count;
			rsp_q.sequential_count <= cnt_next.sequential_count;
			rsp_q.random_count <= cnt_next.random_count;
		end
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_issue))
		else $error("tag write during scan read");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_cnt_q < n_q) && (n_q != '0))
		else $error("scan beyond slots in use");

	a_idle_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q == S_IDLE) && rsp_valid)
		else $error("finish did not return to idle");
`endif

endmodule

>>> hdl/lbcd_tag_ram.sv
// ----------------------------------------------------------------------------
// lbcd_tag_ram
// Slot tag memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbcd_tag_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 111
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lbcd_scan.sv
// ----------------------------------------------------------------------------
// lbcd_scan
// Per-slot evaluation of the read stream: first match, first empty slot and
// oldest stamp (lowest index on a tie).
// ----------------------------------------------------------------------------
module lbcd_scan #(
	parameter int ENTRIES = 64,
	parameter int STAMP_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        dv,
	input  logic [$clog2(ENTRIES)-1:0]  idx,
	input  logic                        ent_valid,
	input  logic [lbcd_pkg::USER_W-1:0]  ent_user,
	input  logic [lbcd_pkg::BLOCK_W-1:0] ent_block,
	input  logic [STAMP_BITS-1:0]       ent_stamp,
	input  logic [lbcd_pkg::USER_W-1:0]  key_user,
	input  logic [lbcd_pkg::BLOCK_W-1:0] key_block,
	output lbcd_pkg::scan_flags_t       flags,
	output logic [$clog2(ENTRIES)-1:0]  hit_idx,
	output logic [$clog2(ENTRIES)-1:0]  empty_idx,
	output logic [$clog2(ENTRIES)-1:0]  lru_idx
);
	import lbcd_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic                  hit_q;
	logic                  empty_q;
	logic                  first_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [IDX_W-1:0]      empty_idx_q;
	logic [IDX_W-1:0]      lru_idx_q;
	logic [STAMP_BITS-1:0] lru_stamp_q;
	logic                  match;

	assign match = ent_valid && (ent_user == key_user) && (ent_block == key_block);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			empty_q <= 1'b0;
			first_q <= 1'b1;
		end else if (start) begin
			hit_q <= 1'b0;
			empty_q <= 1'b0;
			first_q <= 1'b1;
		end else if (dv) begin
			first_q <= 1'b0;
			if (match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!ent_valid && !empty_q) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv) begin
			if (match && !hit_q) begin
				hit_idx_q <= idx;
			end
			if (!ent_valid && !empty_q) begin
				empty_idx_q <= idx;
			end
			if (first_q || (ent_stamp < lru_stamp_q)) begin
				lru_idx_q <= idx;
				lru_stamp_q <= ent_stamp;
			end
		end
	end

	assign flags.hit = hit_q;
	assign flags.empty = empty_q;
	assign hit_idx = hit_idx_q;
	assign empty_idx = empty_idx_q;
	assign lru_idx = lru_idx_q;

endmodule

>>> hdl/lbcd_stats.sv
// ----------------------------------------------------------------------------
// lbcd_stats
// Saturating request and page statistics, with previous-store tracking for
// the sequential versus random split.
// ----------------------------------------------------------------------------
module lbcd_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [1:0]                  op,
	input  logic [1:0]                  kind,
	input  logic [lbcd_pkg::USER_W-1:0]  user,
	input  logic [lbcd_pkg::BLOCK_W-1:0] block,
	output lbcd_pkg::stats_t            cnt_next
);
	import lbcd_pkg::*;

	stats_t             cnt_q;
	logic [USER_W-1:0]  prev_user_q;
	logic [BLOCK_W-1:0] prev_block_q;
	logic               prev_valid_q;
	logic               near;
	logic               seq;
	logic [BLOCK_W:0]   prev_ext;
	logic [BLOCK_W:0]   blk_ext;

	function automatic logic [STAT_W-1:0] bump(input logic [STAT_W-1:0] v);
		return (v == STAT_MAX) ? v : v + 1'b1;
	endfunction

	assign prev_ext = {1'b0, prev_block_q};
	assign blk_ext = {1'b0, block};
	assign near = (prev_ext == blk_ext) || (prev_ext + 1'b1 == blk_ext)
		|| (blk_ext + 1'b1 == prev_ext);
	assign seq = prev_valid_q && (prev_user_q == user) && near;

	always_comb begin
		cnt_next = cnt_q;
		case (op)
			OP_LOOKUP: begin
				cnt_next.request_count = bump(cnt_q.request_count);
			end
			OP_STORE: begin
				if (kind == KIND_DATA) begin
					cnt_next.data_page_count = bump(cnt_q.data_page_count);
				end else if (kind == KIND_INDEX) begin
					cnt_next.index_page_count = bump(cnt_q.index_page_count);
				end
				if (seq) begin
					cnt_next.sequential_count = bump(cnt_q.sequential_count);
				end else begin
					cnt_next.random_count = bump(cnt_q.random_count);
				end
			end
			OP_CLR_STATS: begin
				cnt_next = '0;
			end
			default: begin
				cnt_next = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			prev_user_q <= '0;
			prev_block_q <= '0;
			prev_valid_q <= 1'b0;
		end else if (upd) begin
			cnt_q <= cnt_next;
			if (op == OP_STORE) begin
				prev_user_q <= user;
				prev_block_q <= block;
				prev_valid_q <= 1'b1;
			end else if (op == OP_CLR_CACHE) begin
				prev_valid_q <= 1'b0;
			end
		end
	end

endmodule
